// ===== rtl/core/fwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwsm_pkg
// shared types and constants of the four wheel steering mixer
// ----------------------------------------------------------------------------
package fwsm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_AUTONOMOUS = 3'd0;
  localparam logic [2:0] REG_MAX_ROT    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_SCALE      = 3'd3;

  // register reset values
  localparam logic [14:0] MAX_ROT_RST   = 15'd2048;
  localparam logic [14:0] THRESHOLD_RST = 15'd1024;
  localparam logic [15:0] SCALE_RST     = 16'd4096;

  // steering modes
  localparam logic [2:0] MODE_FRONT   = 3'd0;
  localparam logic [2:0] MODE_REAR    = 3'd1;
  localparam logic [2:0] MODE_PADDLE  = 3'd2;
  localparam logic [2:0] MODE_COUNTER = 3'd3;
  localparam logic [2:0] MODE_CRAB    = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture request and step the mode
    logic mul_en;    // register the shared product
    logic mul_rear;  // multiplier operands: offset by gain, else stick by rotation
    logic diff;      // round the angle and form the threshold offset
    logic out_load;  // load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic autonomous;
  } sts_t;

endpackage

// ===== rtl/core/fwsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwsm_ctrl
// sequencer and output handshake of the steering mixer
// ----------------------------------------------------------------------------
module fwsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  fwsm_pkg::sts_t  sts_i,
  output fwsm_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ANGLE  = 3'd1;
  localparam logic [2:0] ST_DIFF   = 3'd2;
  localparam logic [2:0] ST_REAR   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.autonomous) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_REAR;
      end
      ST_REAR: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_rear = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fwsm_dp.sv =====
// ----------------------------------------------------------------------------
// fwsm_dp
// datapath of the steering mixer: registers, mode, shared multiplier, result
// ----------------------------------------------------------------------------
module fwsm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwsm_pkg::cmd_t     cmd_i,
  output fwsm_pkg::sts_t     sts_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [15:0] axis_position_i,
  input  logic               mode_up_i,
  input  logic               mode_down_i,
  input  logic               right_paddle_i,
  input  logic               left_paddle_i,
  output logic signed [15:0] front_angle_o,
  output logic signed [15:0] rear_angle_o,
  output logic [2:0]         active_mode_o
);

  // configuration
  logic        auto_q;
  logic [14:0] max_rot_q;
  logic [14:0] thresh_q;
  logic [15:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q    <= 1'b0;
      max_rot_q <= fwsm_pkg::MAX_ROT_RST;
      thresh_q  <= fwsm_pkg::THRESHOLD_RST;
      scale_q   <= fwsm_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fwsm_pkg::REG_AUTONOMOUS: auto_q    <= cfg_data_i[0];
        fwsm_pkg::REG_MAX_ROT:    max_rot_q <= cfg_data_i[14:0];
        fwsm_pkg::REG_THRESHOLD:  thresh_q  <= cfg_data_i[14:0];
        fwsm_pkg::REG_SCALE:      scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sts_o.autonomous = auto_q;

  // steering mode
  logic [2:0] mode_q, mode_d;

  always_comb begin
    mode_d = mode_q;
    priority if (mode_up_i) begin
      mode_d = (mode_q >= fwsm_pkg::MODE_CRAB) ? fwsm_pkg::MODE_FRONT : mode_q + 3'd1;
    end else if (mode_down_i) begin
      priority if (mode_q == fwsm_pkg::MODE_FRONT) begin
        mode_d = fwsm_pkg::MODE_CRAB;
      end else if (mode_q > fwsm_pkg::MODE_CRAB) begin
        mode_d = fwsm_pkg::MODE_COUNTER;
      end else begin
        mode_d = mode_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fwsm_pkg::MODE_FRONT;
    end else if (cmd_i.load) begin
      mode_q <= mode_d;
    end
  end

  // captured request
  logic signed [15:0] axis_q;
  logic               rpad_q, lpad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      axis_q <= axis_position_i;
      rpad_q <= right_paddle_i;
      lpad_q <= left_paddle_i;
    end
  end

  // shared multiplier
  logic signed [16:0] d_q;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic signed [33:0] prod_q;

  always_comb begin
    if (cmd_i.mul_rear) begin
      mul_a = d_q;
      mul_b = $signed({1'b0, scale_q});
    end else begin
      mul_a = $signed({axis_q[15], axis_q});
      mul_b = $signed({2'b00, max_rot_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  // angle rounding and threshold offset
  logic signed [33:0] ang_sum;
  logic signed [15:0] ang;
  logic signed [16:0] ang_x, off_up, off_dn, off;
  logic signed [15:0] angle_q;

  assign ang_sum = prod_q + 34'sd16384;
  assign ang     = $signed(ang_sum[30:15]);
  assign ang_x   = {ang[15], ang};
  assign off_up  = ang_x - $signed({2'b00, thresh_q});
  assign off_dn  = ang_x + $signed({2'b00, thresh_q});

  always_comb begin
    priority if (off_up > 17'sd0) begin
      off = off_up;
    end else if (off_dn < 17'sd0) begin
      off = off_dn;
    end else begin
      off = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      angle_q <= ang;
      d_q     <= (mode_q == fwsm_pkg::MODE_COUNTER) ? -off : off;
    end
  end

  // rear rounding, saturation and mode mixing
  logic signed [33:0] rear_sum;
  logic signed [21:0] rear_sh;
  logic signed [15:0] rear_sat;
  logic signed [15:0] front_d, rear_d;
  logic               pad_take;

  assign rear_sum = prod_q + 34'sd2048;
  assign rear_sh  = $signed(rear_sum[33:12]);

  always_comb begin
    priority if (rear_sh > 22'sd32767) begin
      rear_sat = 16'sh7FFF;
    end else if (rear_sh < -22'sd32768) begin
      rear_sat = -16'sh8000;
    end else begin
      rear_sat = rear_sh[15:0];
    end
  end

  assign pad_take = (lpad_q && angle_q > 16'sd0) || (rpad_q && angle_q < 16'sd0);

  always_comb begin
    front_d = angle_q;
    unique case (mode_q)
      fwsm_pkg::MODE_FRONT:  rear_d = '0;
      fwsm_pkg::MODE_REAR: begin
        front_d = '0;
        rear_d  = angle_q;
      end
      fwsm_pkg::MODE_PADDLE: rear_d = pad_take ? angle_q : 16'sd0;
      default:               rear_d = rear_sat;
    endcase
  end

  logic signed [15:0] front_q, rear_q;
  logic [2:0]         mode_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      front_q    <= front_d;
      rear_q     <= rear_d;
      mode_out_q <= (mode_q > fwsm_pkg::MODE_CRAB) ? fwsm_pkg::MODE_CRAB : mode_q;
    end
  end

  assign front_angle_o = front_q;
  assign rear_angle_o  = rear_q;
  assign active_mode_o = mode_out_q;

endmodule

// ===== rtl/core/four_wheel_steer_mixer.sv =====
// ----------------------------------------------------------------------------
// four_wheel_steer_mixer
// turns steering stick samples into front and rear wheel angle commands
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              carries
//  in        sink       in_valid_i/in_stall_o    axis, mode buttons, paddles
//  out       source     out_valid_o/out_stall_i  front angle, rear angle, mode
//  cfg       sink       cfg_valid_i/cfg_ready_o  register index and data
//
//  a request holds the block from accept through stick multiply, offset,
//  rear multiply and result load; one 17x17 multiplier serves both products
//  reset (rst_ni low, asynchronous) restores register defaults, front mode
//  a request taken while autonomous is set is dropped, block stays idle
//  a stalled result sits in the output register while the next request is
//  worked on; the sequencer waits at result load only if that is still full
//
module four_wheel_steer_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] axis_position_i,
  input  logic               mode_up_i,
  input  logic               mode_down_i,
  input  logic               right_paddle_i,
  input  logic               left_paddle_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] front_angle_o,
  output logic signed [15:0] rear_angle_o,
  output logic [2:0]         active_mode_o,
  // configuration channel, always ready
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  fwsm_pkg::cmd_t cmd;
  fwsm_pkg::sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: stalls requests while busy, owns the result valid
  fwsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: config registers, mode, shared multiplier, result register
  fwsm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .axis_position_i (axis_position_i),
    .mode_up_i       (mode_up_i),
    .mode_down_i     (mode_down_i),
    .right_paddle_i  (right_paddle_i),
    .left_paddle_i   (left_paddle_i),
    .front_angle_o   (front_angle_o),
    .rear_angle_o    (rear_angle_o),
    .active_mode_o   (active_mode_o)
  );

endmodule
